[design/text_terminal_engine_macros.svh]
// Assertion macros for the text terminal engine.
`ifndef TEXT_TERMINAL_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define TTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TTE_ASSERT(lbl, prop, msg)
`define TTE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

[design/tte_pkg.sv]
// Shared constants of the text terminal engine: field widths and character codes.
package tte_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CELL_IN_W = 10;
  localparam int unsigned COL_OUT_W = 6;
  localparam int unsigned ROW_OUT_W = 5;

  localparam logic [CHAR_W-1:0] CH_BEL   = 8'd7;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_HT    = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'd27;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
  localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_J     = 8'h4A;
  localparam logic [CHAR_W-1:0] CH_K     = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_Y     = 8'h59;

  localparam logic [CHAR_W-1:0] CELL_RESET = 8'd0;

endpackage

[design/tte_channels.sv]
// Valid/ready channel interfaces for the terminal input and result streams.
interface tte_in_if;
  import tte_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [CHAR_W-1:0]    char_code;
  logic [CELL_IN_W-1:0] cell_address;

  modport source (output valid, output mode, output char_code, output cell_address,
                  input ready);
  modport sink   (input valid, input mode, input char_code, input cell_address,
                  output ready);
endinterface

interface tte_out_if;
  import tte_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic                 bell;
  logic [CHAR_W-1:0]    cell_data;

  modport source (output valid, output cursor_col, output cursor_row, output bell,
                  output cell_data, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row, input bell,
                  input cell_data, output ready);
endinterface

[design/tte_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
module tte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 960
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/text_terminal_engine.sv]
// Top level of the text terminal engine: cursor, escape parser and screen store.
//
//  channel   | dir | payload                                    | transaction
//  in_ch_i   | in  | mode, char_code, cell_address              | valid & ready
//  out_ch_o  | out | cursor_col, cursor_row, bell, cell_data     | valid & ready
//
// One item at a time: a put byte goes through the execute and finish steps, a cell read
// adds a RAM read wait step between them, and a read past the screen skips the RAM.
// ESC K/J/E and FF fill one cell per cycle.
// A scroll copies one cell per cycle through the RAM port pair, then fills the
// bottom row, for the put that causes it.
// After reset a clearing pass writes zero to all COLUMNS*ROWS cells, one per cycle,
// before the first item is taken. A waiting result sits in the output register
// while the next item is accepted; a stalled output delays only the finish step.
`include "text_terminal_engine_macros.svh"

module text_terminal_engine #(
  parameter int unsigned COLUMNS = 40,
  parameter int unsigned ROWS    = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tte_in_if.sink    in_ch_i,
  tte_out_if.source out_ch_o
);
  import tte_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned CMP_W  = (CNT_W > CELL_IN_W) ? CNT_W : CELL_IN_W;
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned COLX_W = COL_W + 1;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ROWX_W = ROW_W + 1;

  localparam logic [CNT_W-1:0] CELLS_C   = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] LAST_BASE = CNT_W'(COLUMNS * (ROWS - 1));
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELLS - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_RDWAIT, ST_SCROLL, ST_FILL, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_NONE, PH_ESC, PH_ROW, PH_COL
  } phase_e;

  function automatic logic [CHAR_W-1:0] coord(input logic [CHAR_W-1:0] c,
                                              input logic [CHAR_W-1:0] lim_m1);
    logic [CHAR_W-1:0] v;
    v = (c >= CH_SPACE) ? c - CH_SPACE : '0;
    return (v > lim_m1) ? lim_m1 : v;
  endfunction

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [ROW_W-1:0]     pend_q, pend_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     end_q, end_d;
  logic                 mode_q, mode_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic [CELL_IN_W-1:0] addr_q, addr_d;
  logic                 bell_q, bell_d;
  logic [CHAR_W-1:0]    data_q, data_d;
  logic                 wpend_q, wpend_d;
  logic [ADDR_W-1:0]    wpaddr_q, wpaddr_d;
  logic                 ov_q, ov_d;
  logic [COL_OUT_W-1:0] ocol_q, ocol_d;
  logic [ROW_OUT_W-1:0] orow_q, orow_d;
  logic                 obell_q, obell_d;
  logic [CHAR_W-1:0]    odata_q, odata_d;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [CHAR_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [CHAR_W-1:0]    ram_rdata;

  logic [CNT_W-1:0]     base;
  logic [CNT_W-1:0]     row_base;
  logic [CNT_W-1:0]     scr_src;
  logic [COLX_W-1:0]    col_n;
  logic [ROWX_W-1:0]    row_n;
  logic                 normal;
  logic                 fill_go;
  logic                 scroll_go;
  logic [CNT_W-1:0]     fill_lo;
  logic [CNT_W-1:0]     fill_hi;

  tte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row_base = CNT_W'(row_q) * CNT_W'(COLUMNS);
  assign base     = row_base + CNT_W'(col_q);
  assign scr_src  = ptr_q + CNT_W'(COLUMNS);

  assign in_ch_i.ready       = (state_q == ST_IDLE);
  assign out_ch_o.valid      = ov_q;
  assign out_ch_o.cursor_col = ocol_q;
  assign out_ch_o.cursor_row = orow_q;
  assign out_ch_o.bell       = obell_q;
  assign out_ch_o.cell_data  = odata_q;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    col_d     = col_q;
    row_d     = row_q;
    pend_d    = pend_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    mode_d    = mode_q;
    char_d    = char_q;
    addr_d    = addr_q;
    bell_d    = bell_q;
    data_d    = data_q;
    wpend_d   = wpend_q;
    wpaddr_d  = wpaddr_q;
    ov_d      = ov_q;
    ocol_d    = ocol_q;
    orow_d    = orow_q;
    obell_d   = obell_q;
    odata_d   = odata_q;
    ram_we    = 1'b0;
    ram_waddr = base[ADDR_W-1:0];
    ram_wdata = char_q;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(addr_q);
    col_n     = COLX_W'(col_q);
    row_n     = ROWX_W'(row_q);
    normal    = 1'b0;
    fill_go   = 1'b0;
    scroll_go = 1'b0;
    fill_lo   = '0;
    fill_hi   = CELLS_C;

    if (out_ch_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[ADDR_W-1:0];
        ram_wdata = CELL_RESET;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch_i.valid) begin
          mode_d  = in_ch_i.mode;
          char_d  = in_ch_i.char_code;
          addr_d  = in_ch_i.cell_address;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        bell_d = 1'b0;
        data_d = '0;
        if (mode_q) begin
          // addresses past the screen read as zero
          if (CMP_W'(addr_q) < CMP_W'(CELLS)) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(addr_q);
            state_d   = ST_RDWAIT;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          normal = 1'b1;
          case (phase_q)
            PH_ESC: begin
              phase_d = PH_NONE;
              normal  = 1'b0;
              case (char_q)
                CH_Y: phase_d = PH_ROW;
                CH_K: begin
                  fill_go = 1'b1;
                  fill_lo = base;
                  fill_hi = row_base + CNT_W'(COLUMNS);
                end
                CH_J: begin
                  fill_go = 1'b1;
                  fill_lo = base;
                end
                CH_H: begin
                  col_n = '0;
                  row_n = '0;
                end
                CH_E: begin
                  fill_go = 1'b1;
                  col_n   = '0;
                  row_n   = '0;
                end
                default: normal = 1'b1;  // unknown code: byte handled as ordinary
              endcase
            end
            PH_ROW: begin
              pend_d  = ROW_W'(coord(char_q, CHAR_W'(ROWS - 1)));
              phase_d = PH_COL;
              normal  = 1'b0;
            end
            PH_COL: begin
              row_n   = ROWX_W'(pend_q);
              col_n   = COLX_W'(coord(char_q, CHAR_W'(COLUMNS - 1)));
              phase_d = PH_NONE;
              normal  = 1'b0;
            end
            default: ;
          endcase

          if (normal) begin
            case (char_q) inside
              CH_BEL: bell_d = 1'b1;
              CH_BS: begin
                if (col_q == '0) begin
                  if (row_q != '0) begin
                    col_n = COLX_W'(COLUMNS - 1);
                    row_n = ROWX_W'(row_q) - 1'b1;
                  end
                end else begin
                  col_n = COLX_W'(col_q) - 1'b1;
                end
              end
              CH_HT: col_n = (COLX_W'(col_q) + COLX_W'(8)) & ~COLX_W'(7);
              CH_LF, CH_VT: row_n = ROWX_W'(row_q) + 1'b1;
              CH_FF: begin
                fill_go = 1'b1;
                col_n   = '0;
                row_n   = '0;
              end
              CH_CR:  col_n = '0;
              CH_ESC: phase_d = PH_ESC;
              CH_DEL: ;
              default: begin
                ram_we = 1'b1;
                col_n  = COLX_W'(col_q) + 1'b1;
              end
            endcase
            // the column never passes twice the width, the row one past the bottom
            if (col_n >= COLX_W'(COLUMNS)) begin
              col_n = col_n - COLX_W'(COLUMNS);
              row_n = row_n + 1'b1;
            end
            if (row_n >= ROWX_W'(ROWS)) begin
              row_n     = ROWX_W'(ROWS - 1);
              scroll_go = 1'b1;
            end
          end

          col_d = COL_W'(col_n);
          row_d = ROW_W'(row_n);
          if (scroll_go) begin
            ptr_d   = '0;
            wpend_d = 1'b0;
            state_d = ST_SCROLL;
          end else if (fill_go) begin
            ptr_d   = fill_lo;
            end_d   = fill_hi;
            state_d = ST_FILL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_RDWAIT: begin
        data_d  = ram_rdata;
        state_d = ST_DONE;
      end

      ST_SCROLL: begin
        // read cell i+COLUMNS, write it to cell i in the next cycle
        if (wpend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wpaddr_q;
          ram_wdata = ram_rdata;
        end
        if (ptr_q < LAST_BASE) begin
          ram_re    = 1'b1;
          ram_raddr = scr_src[ADDR_W-1:0];
          wpend_d   = 1'b1;
          wpaddr_d  = ptr_q[ADDR_W-1:0];
          ptr_d     = ptr_q + 1'b1;
        end else begin
          wpend_d = 1'b0;
          end_d   = CELLS_C;
          state_d = ST_FILL;
        end
      end

      ST_FILL: begin
        if (ptr_q < end_q) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q[ADDR_W-1:0];
          ram_wdata = CH_SPACE;
          ptr_d     = ptr_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!ov_q || out_ch_o.ready) begin
          ov_d    = 1'b1;
          ocol_d  = COL_OUT_W'(col_q);
          orow_d  = ROW_OUT_W'(row_q);
          obell_d = bell_q;
          odata_d = data_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      phase_q <= PH_NONE;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      ptr_q   <= '0;
      wpend_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      ptr_q   <= ptr_d;
      wpend_q <= wpend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q    <= end_d;
    mode_q   <= mode_d;
    char_q   <= char_d;
    addr_q   <= addr_d;
    bell_q   <= bell_d;
    data_q   <= data_d;
    wpaddr_q <= wpaddr_d;
    ocol_q   <= ocol_d;
    orow_q   <= orow_d;
    obell_q  <= obell_d;
    odata_q  <= odata_d;
  end

  `TTE_ASSERT(a_cursor_range,
              (row_q < ROW_W'(ROWS - 1) || row_q == ROW_W'(ROWS - 1)),
              "cursor row off screen")
  `TTE_ASSERT_IMP(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr,
                  "read and write hit one cell")
  `TTE_ASSERT_IMP(a_scroll_handoff, state_q == ST_SCROLL && state_d == ST_FILL,
                  ##1 (ptr_q == LAST_BASE && end_q == CELLS_C),
                  "scroll did not end at bottom row")
  `TTE_ASSERT_IMP(a_busy_no_accept, state_q != ST_IDLE, !in_ch_i.ready,
                  "input taken while busy")

endmodule
